@@ sv/idq_pkg.sv @@
package idq_pkg;

  // Storage geometry.
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Fixed field widths of the channels.
  localparam int FUNC_W   = 3;
  localparam int WORD_W   = 32;
  localparam int INDEX_W  = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [FUNC_W-1:0]     func_t;
  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [INDEX_W-1:0]    index_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [STATUS_W-1:0]   status_t;

  // Operation codes.
  localparam func_t OP_INS_REAR  = 3'd0;
  localparam func_t OP_INS_FRONT = 3'd1;
  localparam func_t OP_REM_FRONT = 3'd2;
  localparam func_t OP_REM_REAR  = 3'd3;
  localparam func_t OP_READ      = 3'd4;

  // Status codes.
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

  // Decoded control for one operation.
  typedef struct packed {
    logic    wr_en;
    ptr_t    wr_addr;
    logic    rd_en;
    ptr_t    rd_addr;
    ptr_t    head_next;
    cnt_t    held_next;
    status_t status;
  } ctl_t;

endpackage

@@ sv/idq_if.sv @@
interface idq_req_if
  import idq_pkg::*;
();
  logic   valid;
  logic   ready;
  func_t  func;
  word_t  value;
  index_t index;

  modport source (output valid, output func, output value, output index, input ready);
  modport sink   (input valid, input func, input value, input index, output ready);
endinterface

interface idq_rsp_if
  import idq_pkg::*;
();
  logic    valid;
  logic    ready;
  word_t   read_data;
  count_t  count;
  logic    is_empty;
  status_t status;

  modport source (output valid, output read_data, output count, output is_empty,
                  output status, input ready);
  modport sink   (input valid, input read_data, input count, input is_empty,
                  input status, output ready);
endinterface

@@ sv/idq_decode.sv @@
module idq_decode
  import idq_pkg::*;
(
  input  func_t  func,
  input  index_t index,
  input  ptr_t   head,
  input  cnt_t   held,
  output ctl_t   ctl
);

  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  // Ring addition; base is below DEPTH and off at most DEPTH, so one
  // conditional subtraction wraps it.
  function automatic ptr_t ring_add(ptr_t base, cnt_t off);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  logic full;
  logic empty;
  logic out_of_range;
  ptr_t head_dec;

  assign full         = (held == cnt_t'(DEPTH));
  assign empty        = (held == '0);
  assign out_of_range = (CMP_W'(index) >= CMP_W'(held));
  assign head_dec     = ring_add(head, cnt_t'(DEPTH - 1));

  always_comb begin
    ctl.wr_en     = 1'b0;
    ctl.wr_addr   = ring_add(head, held);
    ctl.rd_en     = 1'b0;
    ctl.rd_addr   = ring_add(head, cnt_t'(index));
    ctl.head_next = head;
    ctl.held_next = held;
    ctl.status    = ST_OK;
    unique case (func)
      OP_INS_REAR: begin
        if (full) begin
          ctl.status = ST_FULL;
        end else begin
          ctl.wr_en     = 1'b1;
          ctl.held_next = held + cnt_t'(1);
        end
      end
      OP_INS_FRONT: begin
        if (full) begin
          ctl.status = ST_FULL;
        end else begin
          ctl.wr_en     = 1'b1;
          ctl.wr_addr   = head_dec;
          ctl.head_next = head_dec;
          ctl.held_next = held + cnt_t'(1);
        end
      end
      OP_REM_FRONT: begin
        if (empty) begin
          ctl.status = ST_EMPTY;
        end else begin
          ctl.head_next = ring_add(head, cnt_t'(1));
          ctl.held_next = held - cnt_t'(1);
        end
      end
      OP_REM_REAR: begin
        if (empty) begin
          ctl.status = ST_EMPTY;
        end else begin
          ctl.held_next = held - cnt_t'(1);
        end
      end
      OP_READ: begin
        if (out_of_range) begin
          ctl.status = ST_RANGE;
        end else begin
          ctl.rd_en = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/indexed_double_ended_queue_core.sv @@
// Double-ended queue of DEPTH words held in a ring buffer in one synchronous
// memory. Each request item carries one operation (insert at rear, insert at
// front, remove front, remove rear, or read at a logical index from the
// front) and produces exactly one response item with the word read (zero
// unless a successful read), the element count after the operation, an empty
// flag and a status code. For inserts and removes the ring pointers update
// and the memory write happen at the accept edge, where the response is
// registered too. For a successful read the memory read port registers the
// word at the accept edge and the response register takes it from S_READ
// with the valid. Refused inserts (full), removes from an empty list and
// out-of-range reads leave the contents untouched. The response sits in an
// output register, so a new item is taken in the cycle the pending response
// is taken, except while a read is in S_READ. Memory entries have no reset;
// only entries inside the held range are ever read.
module indexed_double_ended_queue_core
  import idq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  idq_req_if.sink   req,
  idq_rsp_if.source rsp
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic  state;
  ptr_t  head;
  cnt_t  held;
  ctl_t  ctl;
  logic  accept;

  data_t mem [DEPTH];
  data_t rdata;

  logic    rsp_valid;
  word_t   rsp_data;
  count_t  rsp_count;
  logic    rsp_empty;
  status_t rsp_status;

  idq_decode u_decode (
    .func  (req.func),
    .index (req.index),
    .head  (head),
    .held  (held),
    .ctl   (ctl)
  );

  // An item is taken only out of reset, when idle and the response slot is
  // free or being emptied at this edge.
  assign req.ready = !rst && (state == S_IDLE) && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  // Ring storage: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && ctl.wr_en) begin
      mem[ctl.wr_addr] <= data_t'(req.value);
    end
    if (accept && ctl.rd_en) begin
      rdata <= mem[ctl.rd_addr];
    end
  end

  // Pointer, count and sequencing state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      held  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            head <= ctl.head_next;
            held <= ctl.held_next;
            if (ctl.rd_en) begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Response register. For a read the count, flag and status are captured
  // at accept and the word lands with the valid in the following cycle, from S_READ.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept && !ctl.rd_en) begin
      rsp_valid <= 1'b1;
    end else if (state == S_READ) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data   <= '0;
      rsp_count  <= count_t'(ctl.held_next);
      rsp_empty  <= (ctl.held_next == '0);
      rsp_status <= ctl.status;
    end else if (state == S_READ) begin
      rsp_data <= word_t'(rdata);
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.read_data = rsp_data;
  assign rsp.count     = rsp_count;
  assign rsp.is_empty  = rsp_empty;
  assign rsp.status    = rsp_status;

endmodule
